// File: rtl/esd_pkg.sv
// esd_pkg: types, character codes and record layouts for the escape sequence decoder
// no dependencies

package esd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_BSLASH = 2'd2,
    MODE_OCTAL  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] QREADY_MAX = QCNT_W'(QDEPTH - 2);

  typedef struct packed {
    mode_t      mode;
    logic [7:0] accum;
    logic [1:0] digits;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{mode: MODE_NORMAL, accum: 8'd0, digits: 2'd0};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    push_t      push;
    dec_state_t state_next;
  } dec_t;

endpackage

// File: rtl/esd_if.sv
// esd_in_if / esd_out_if: valid-ready channels for raw and decoded bytes
// depends on nothing

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/esd_decode.sv
// esd_decode: combinational decode of one raw byte against the current escape state
// depends on esd_pkg

module esd_decode
  import esd_pkg::*;
(
  input  dec_state_t st,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output dec_t       dec
);

  logic       is_oct;
  logic       is_special;
  logic [7:0] accum_ext;
  logic [1:0] digits_inc;
  result_t    norm_res;
  logic       norm_emit;
  mode_t      norm_mode;
  push_t      push;
  dec_state_t state_next;

  assign is_oct     = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign is_special = (in_byte == CH_QUOTE) || (in_byte == CH_BSLASH);
  assign accum_ext  = {st.accum[4:0], in_byte[2:0]};
  assign digits_inc = st.digits + 2'd1;

  assign dec = '{push: push, state_next: state_next};

  // normal-mode handling of the byte
  always_comb begin
    norm_res = '{data: in_byte, last: in_last};
    norm_emit = 1'b1;
    norm_mode = MODE_NORMAL;
    if (is_special) begin
      if (in_last) begin
        norm_res.data = 8'd0;
      end else begin
        norm_emit = 1'b0;
        norm_mode = (in_byte == CH_QUOTE) ? MODE_QUOTE : MODE_BSLASH;
      end
    end
  end

  // next state
  always_comb begin
    state_next = st;
    unique case (st.mode)
      MODE_QUOTE: begin
        state_next.mode = MODE_NORMAL;
      end
      MODE_BSLASH: begin
        state_next.mode = MODE_NORMAL;
        if (is_oct) begin
          state_next.accum = {5'd0, in_byte[2:0]};
          state_next.digits = 2'd1;
          state_next.mode = MODE_OCTAL;
        end
      end
      MODE_OCTAL: begin
        if (is_oct && (st.digits < OCT_MAX_DIGITS)) begin
          state_next.accum = accum_ext;
          state_next.digits = digits_inc;
          if (in_last || (digits_inc >= OCT_MAX_DIGITS)) begin
            state_next = DEC_RESET;
          end
        end else begin
          state_next = DEC_RESET;
          state_next.mode = norm_mode;
        end
      end
      default: begin
        state_next.mode = norm_mode;
      end
    endcase
    if (in_last) begin
      state_next = DEC_RESET;
    end
  end

  // results
  always_comb begin
    push.v0 = 1'b0;
    push.v1 = 1'b0;
    push.r0 = '{data: in_byte, last: in_last};
    push.r1 = norm_res;
    unique case (st.mode)
      MODE_QUOTE: begin
        push.v0 = 1'b1;
      end
      MODE_BSLASH: begin
        push.v0 = 1'b1;
        priority if (in_byte == CH_B) begin
          push.r0.data = CODE_BS;
        end else if (in_byte == CH_F) begin
          push.r0.data = CODE_FF;
        end else if (in_byte == CH_N) begin
          push.r0.data = CODE_LF;
        end else if (in_byte == CH_R) begin
          push.r0.data = CODE_CR;
        end else if (in_byte == CH_T) begin
          push.r0.data = CODE_TAB;
        end else if (is_oct) begin
          push.r0.data = {5'd0, in_byte[2:0]};
          push.v0 = in_last;
        end else begin
          push.r0.data = in_byte;
        end
      end
      MODE_OCTAL: begin
        if (is_oct && (st.digits < OCT_MAX_DIGITS)) begin
          push.r0.data = accum_ext;
          push.v0 = in_last || (digits_inc >= OCT_MAX_DIGITS);
        end else begin
          // pending value first, then the byte as in normal mode
          push.v0 = 1'b1;
          push.r0 = '{data: st.accum, last: 1'b0};
          push.v1 = norm_emit;
        end
      end
      default: begin
        push.v0 = norm_emit;
        push.r0 = norm_res;
      end
    endcase
  end

endmodule

// File: rtl/esd_out_queue.sv
// esd_out_queue: small result queue taking up to two items a cycle, one out
// depends on esd_pkg and esd_out_if

module esd_out_queue
  import esd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space,
  esd_out_if.source tx
);

  result_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_next;
  logic [QPTR_W-1:0]   rd_ptr_next;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;
  logic [1:0]          n_push;

  assign pop    = tx.valid && tx.ready;
  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};

  always_comb begin
    wr_ptr_next = wr_ptr + QPTR_W'(n_push);
    rd_ptr_next = rd_ptr + QPTR_W'(pop);
    count_next  = count + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  assign space       = (count <= QREADY_MAX);
  assign tx.valid    = (count != '0);
  assign tx.out_byte = slots[rd_ptr].data;
  assign tx.out_last = slots[rd_ptr].last;

endmodule

// File: rtl/escape_sequence_decoder.sv
// escape_sequence_decoder: top level of the backslash/quote escape decoder
// depends on esd_pkg, esd_if, esd_decode and esd_out_queue
//
// usage
//   rx carries raw bytes of an escaped string, in_last set on its final byte
//   tx carries decoded bytes, out_last set on the last decoded byte of a string
//   an item on rx yields zero, one or two items on tx
// output
//   a result is registered in the queue, then offered on tx behind earlier results
// throughput
//   one rx item per cycle while tx keeps up; the rare item giving two results
//   is absorbed by the four-entry result queue
//   rx.ready is high while the queue has room for two results
// reset
//   rst (synchronous) returns the escape state to normal and empties the queue
// stalls
//   when tx.ready is low, results wait in the queue and rx.ready drops once
//   fewer than two free slots remain; nothing is lost or repeated

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  esd_in_if.sink    rx,
  esd_out_if.source tx
);

  dec_state_t st;
  dec_t       dec;
  push_t      push;
  logic       space;
  logic       accept;

  assign rx.ready = space;
  assign accept   = rx.valid && space;

  esd_decode u_decode (
    .st      (st),
    .in_byte (rx.in_byte),
    .in_last (rx.in_last),
    .dec     (dec)
  );

  always_comb begin
    push = dec.push;
    push.v0 = dec.push.v0 && accept;
    push.v1 = dec.push.v1 && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DEC_RESET;
    end else if (accept) begin
      st <= dec.state_next;
    end
  end

  esd_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .tx    (tx)
  );

endmodule
